// ----- src/hcg_pkg.sv -----
// Shared constants and types for the level and circular hypervector generator.
package hcg_pkg;

    // Store and set limits
    localparam int MAX_BYTES   = 2048;
    localparam int MAX_VECTORS = 1024;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int VIDX_W     = 10;
    localparam int BIDX_W     = $clog2(MAX_BYTES);
    localparam int MODE_W     = 2;
    localparam int NVEC_W     = 11;
    localparam int VBYTES_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    // Product widths: vector index times size, count times byte offset
    localparam int APROD_W = VIDX_W + VBYTES_W;
    localparam int BPROD_W = NVEC_W + VBYTES_W;
    localparam int CMP_W   = BPROD_W + 1;

    // Limits as register-wide values
    localparam logic [NVEC_W-1:0]   MAX_VECTORS_V = NVEC_W'(MAX_VECTORS);
    localparam logic [VBYTES_W-1:0] MAX_BYTES_V   = VBYTES_W'(MAX_BYTES);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VECTORS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_BYTES = 2'd2;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_HALF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CIRC = 2'd2;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    localparam logic [BYTE_W-1:0] INVERT_MASK = 8'hFF;

    // Which threshold compare an item needs
    typedef enum logic [1:0] {
        CMP_HALF    = 2'd0,
        CMP_FULL    = 2'd1,
        CMP_CIRC_LO = 2'd2,
        CMP_CIRC_HI = 2'd3
    } cmp_kind_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic              is_load;
        logic [BIDX_W-1:0] byte_index;
        logic [BYTE_W-1:0] data;
        logic              out_of_range;
        logic              invert;
    } hcg_item_t;

endpackage

// ----- src/hcg_front.sv -----
// Front end: config registers, input transfer, range checks and threshold compare.
module hcg_front import hcg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  item_valid,
    input  logic                  item_ready,
    output hcg_item_t             item
);

    logic [MODE_W-1:0]   mode_reg;
    logic [NVEC_W-1:0]   num_vectors_reg;
    logic [VBYTES_W-1:0] vector_bytes_reg;

    logic [NVEC_W-1:0]   n_eff;
    logic [VBYTES_W-1:0] size_eff;
    logic [VIDX_W-1:0]   v_in;
    logic [BIDX_W-1:0]   j_in;
    logic [BYTE_W-1:0]   b_in;
    logic [VIDX_W-1:0]   half_n;
    logic [NVEC_W-1:0]   twice_half;
    logic                circ, circ_lo, byte_oor, vec_oor;
    logic [VIDX_W-1:0]   a_mult;
    logic [VBYTES_W-1:0] b_mult;
    cmp_kind_t           kind;
    logic                accept;

    logic                s1_valid_reg;
    logic                s1_load_reg;
    logic [BIDX_W-1:0]   s1_index_reg;
    logic [BYTE_W-1:0]   s1_data_reg;
    logic                s1_oor_reg;
    cmp_kind_t           s1_kind_reg;
    logic [APROD_W-1:0]  s1_aprod_reg;
    logic [BPROD_W-1:0]  s1_bprod_reg;

    logic [CMP_W-1:0]    a1, a2, b1, b2;
    logic                invert;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_HALF;
            num_vectors_reg  <= MAX_VECTORS_V;
            vector_bytes_reg <= MAX_BYTES_V;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MODE:         mode_reg         <= cfg_wdata[MODE_W-1:0];
                CFG_NUM_VECTORS:  num_vectors_reg  <= cfg_wdata[NVEC_W-1:0];
                CFG_VECTOR_BYTES: vector_bytes_reg <= cfg_wdata[VBYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp set size and unpack the input fields
    assign n_eff    = (num_vectors_reg > MAX_VECTORS_V) ? MAX_VECTORS_V : num_vectors_reg;
    assign size_eff = (vector_bytes_reg > MAX_BYTES_V) ? MAX_BYTES_V : vector_bytes_reg;
    assign v_in     = s_tdata[VIDX_W-1:0];
    assign j_in     = s_tdata[VIDX_W+BIDX_W-1:VIDX_W];
    assign b_in     = s_tdata[VIDX_W+BIDX_W+BYTE_W-1:VIDX_W+BIDX_W];

    // Classify: range checks and compare kind
    assign half_n     = n_eff[NVEC_W-1:1];
    assign twice_half = {n_eff[NVEC_W-1:1], 1'b0};
    assign circ       = (mode_reg == MODE_CIRC);
    assign circ_lo    = (v_in < half_n);
    assign byte_oor   = ({1'b0, j_in} >= size_eff);
    assign vec_oor    = ({1'b0, v_in} >= n_eff)
                     || (mode_reg != MODE_HALF && mode_reg != MODE_FULL && !circ)
                     || (circ && ({1'b0, v_in} >= twice_half));

    always_comb begin
        if (circ) begin
            kind = circ_lo ? CMP_CIRC_LO : CMP_CIRC_HI;
        end else if (mode_reg == MODE_HALF) begin
            kind = CMP_HALF;
        end else begin
            kind = CMP_FULL;
        end
    end

    // Multiplier operands: second circular half uses offset index and mirrored tail
    assign a_mult = (kind == CMP_CIRC_HI) ? (v_in - half_n) : v_in;
    assign b_mult = (kind == CMP_CIRC_HI) ? (size_eff - {1'b0, j_in})
                                          : ({1'b0, j_in} + VBYTES_W'(1));

    assign s_tready = !s1_valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    // Stage valid: fill on transfer, drain into the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (item_ready) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Capture classified item and both products
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_load_reg  <= (s_tuser == OP_LOAD);
            s1_index_reg <= j_in;
            s1_data_reg  <= b_in;
            s1_oor_reg   <= byte_oor || ((s_tuser == OP_GEN) && vec_oor);
            s1_kind_reg  <= kind;
            s1_aprod_reg <= APROD_W'(a_mult) * APROD_W'(size_eff);
            s1_bprod_reg <= BPROD_W'(n_eff) * BPROD_W'(b_mult);
        end
    end

    // Threshold compare without division
    assign a1 = CMP_W'(s1_aprod_reg);
    assign a2 = CMP_W'({s1_aprod_reg, 1'b0});
    assign b1 = CMP_W'(s1_bprod_reg);
    assign b2 = {s1_bprod_reg, 1'b0};

    always_comb begin
        unique case (s1_kind_reg)
            CMP_HALF:    invert = (b2 > a1);
            CMP_FULL:    invert = (b1 > a1);
            CMP_CIRC_LO: invert = (b1 <= a2);
            CMP_CIRC_HI: invert = (b1 > a2);
            default:     invert = 1'b0;
        endcase
    end

    assign item_valid        = s1_valid_reg;
    assign item.is_load      = s1_load_reg;
    assign item.byte_index   = s1_index_reg;
    assign item.data         = s1_data_reg;
    assign item.out_of_range = s1_oor_reg;
    assign item.invert       = invert;

endmodule

// ----- src/hcg_queue.sv -----
// Two-entry queue between front and back.
module hcg_queue import hcg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  hcg_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output hcg_item_t out_item
);

    hcg_item_t  entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- src/hcg_back.sv -----
// Back end: base vector store access and output register.
module hcg_back import hcg_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  hcg_item_t            item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    logic [BYTE_W-1:0] base_mem [MAX_BYTES];
    logic [BYTE_W-1:0] rdata_reg;
    logic              out_valid_reg;
    logic              load_reg;
    logic              oor_reg;
    logic              invert_reg;
    logic [BYTE_W-1:0] data_reg;
    logic              take;

    assign item_ready = !out_valid_reg || m_tready;
    assign take       = item_valid && item_ready;

    // Store access: write on load, registered read on generate
    always_ff @(posedge aclk) begin
        if (take && !item.out_of_range) begin
            if (item.is_load) begin
                base_mem[item.byte_index] <= item.data;
            end else begin
                rdata_reg <= base_mem[item.byte_index];
            end
        end
    end

    // Output valid: set on take, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold result attributes
    always_ff @(posedge aclk) begin
        if (take) begin
            load_reg   <= item.is_load;
            oor_reg    <= item.out_of_range;
            invert_reg <= item.invert;
            data_reg   <= item.data;
        end
    end

    // Form output byte
    always_comb begin
        if (oor_reg) begin
            m_tdata = '0;
        end else if (load_reg) begin
            m_tdata = data_reg;
        end else begin
            m_tdata = invert_reg ? (rdata_reg ^ INVERT_MASK) : rdata_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = oor_reg;

endmodule

// ----- src/level_circular_hypervector_gen.sv -----
// Top level of the level and circular hypervector generator.
//
//  Channel  Direction  Transfer when           Contents
//  s_       in         s_tvalid && s_tready    load base byte or generate request
//  m_       out        m_tvalid && m_tready    one byte and range flag per request
//  cfg_     in         cfg_wr_en               mode, num_vectors, vector_bytes
//
// One item per cycle sustained while the output is not stalled; after the input
// transfer an item passes the product stage, the queue entry and the store read
// into the output register before m_tvalid rises.
// Threshold tests compare two registered products, so no divider is used.
// aresetn is synchronous and active low; the base store is not cleared.
// Output stalls back up through the two-entry queue to s_tready.
module level_circular_hypervector_gen import hcg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,  // vector_index, byte_index, base_byte
    input  logic                  s_tuser,  // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,  // out_byte
    output logic                  m_tuser   // out_of_range
);

    logic      fq_valid, fq_ready;
    hcg_item_t fq_item;
    logic      qb_valid, qb_ready;
    hcg_item_t qb_item;

    hcg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    hcg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    hcg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (qb_valid),
        .item_ready (qb_ready),
        .item       (qb_item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for the level and circular hypervector generator.
module tb_top import hcg_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;  // unassigned mode code
    localparam int SETTLE_CYC  = 8;
    localparam int HOLD_CYC    = 400;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 75;
    localparam int NUM_PHASES  = 14;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic              op;
        logic [VIDX_W-1:0] vec_idx;
        logic [BIDX_W-1:0] byte_idx;
        logic [BYTE_W-1:0] byte_val;
    } hv_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_of_range;
    } hv_res_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // vector_index, byte_index, base_byte
    logic                  s_tuser   = 1'b0;  // op
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;  // out_byte
    logic                  m_tuser;  // out_of_range

    // Configuration as the block holds it
    logic [MODE_W-1:0]   cfg_mode   = MODE_HALF;
    logic [NVEC_W-1:0]   cfg_nvec   = MAX_VECTORS_V;
    logic [VBYTES_W-1:0] cfg_vbytes = MAX_BYTES_V;

    // Mirror of the base store and which bytes the stimulus has loaded
    logic [BYTE_W-1:0] base_mirror [MAX_BYTES];
    bit                loaded      [MAX_BYTES];
    int unsigned       loaded_idx [$];

    hv_req_t req_pending_q [$];
    hv_res_t hv_expect_q [$];
    hv_req_t cur_req;

    int unsigned pushed_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned err_cnt      = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_ack     = 0;

    level_circular_hypervector_gen u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int unsigned eff_vecs();
        return (cfg_nvec > MAX_VECTORS) ? MAX_VECTORS : cfg_nvec;
    endfunction

    function automatic int unsigned eff_bytes();
        return (cfg_vbytes > MAX_BYTES) ? MAX_BYTES : cfg_vbytes;
    endfunction

    function automatic int unsigned draw_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Expected byte for one request; a load also updates the mirror
    function automatic hv_res_t predict_hv_byte(input hv_req_t r);
        hv_res_t          res;
        longint unsigned  n, sz, v, j, t, h, f;
        logic             flip;
        res.out_byte     = '0;
        res.out_of_range = 1'b1;
        n  = eff_vecs();
        sz = eff_bytes();
        v  = r.vec_idx;
        j  = r.byte_idx;
        if (j >= sz) return res;
        if (r.op == OP_LOAD) begin
            base_mirror[j]   = r.byte_val;
            res.out_byte     = r.byte_val;
            res.out_of_range = 1'b0;
            return res;
        end
        if (v >= n || cfg_mode > MODE_CIRC) return res;
        if (cfg_mode != MODE_CIRC) begin
            // level: keep below the threshold, invert from it on
            f    = (cfg_mode == MODE_HALF) ? 2 : 1;
            t    = (v * sz) / (n * f);
            flip = (j >= t);
        end else begin
            h = n / 2;
            if (v < h) begin
                t    = (v * sz * 2) / n;
                flip = (j < t);
            end else if (v < 2 * h) begin
                t    = ((v - h) * sz * 2) / n;
                flip = (j + t < sz);
            end else begin
                return res;  // last vector of an odd count is unused
            end
        end
        res.out_byte     = flip ? (base_mirror[j] ^ INVERT_MASK) : base_mirror[j];
        res.out_of_range = 1'b0;
        return res;
    endfunction

    // Queue one request and track which base bytes it fills
    function automatic void queue_req(input logic op, input int unsigned v,
                                      input int unsigned j, input int unsigned b);
        hv_req_t r;
        r.op       = op;
        r.vec_idx  = VIDX_W'(v);
        r.byte_idx = BIDX_W'(j);
        r.byte_val = BYTE_W'(b);
        req_pending_q.push_back(r);
        pushed_cnt++;
        if (op == OP_LOAD && j < eff_bytes()) begin
            if (!loaded[j]) loaded_idx.push_back(j);
            loaded[j] = 1'b1;
        end
    endfunction

    // Random request: mostly in-range generates on loaded bytes
    function automatic void add_random_req();
        int unsigned nsz, nv, pick, v, j, b;
        logic        op;
        nsz = eff_bytes();
        nv  = eff_vecs();
        b   = $urandom_range(0, 255);
        v   = (nv > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, nv - 1)
                                                     : $urandom_range(0, 1023);
        j   = (nsz > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, nsz - 1)
                                                      : $urandom_range(0, 2047);
        if ($urandom_range(0, 99) < 25) begin
            op = OP_LOAD;
        end else begin
            op = OP_GEN;
            if (loaded_idx.size() > 0 && $urandom_range(0, 99) < 75) begin
                for (int k = 0; k < 8; k++) begin
                    pick = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
                    if (pick < nsz) begin
                        j = pick;
                        break;
                    end
                end
            end
            // never read a base byte that was not loaded: load it instead
            if (j < nsz && !loaded[j]) op = OP_LOAD;
        end
        queue_req(op, v, j, b);
    endfunction

    task automatic set_cfg(input logic [MODE_W-1:0] m, input int unsigned nv,
                           input int unsigned vb);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_wdata <= CFG_DATA_W'(m);
        @(posedge aclk);
        cfg_index <= CFG_NUM_VECTORS;
        cfg_wdata <= CFG_DATA_W'(nv);
        @(posedge aclk);
        cfg_index <= CFG_VECTOR_BYTES;
        cfg_wdata <= CFG_DATA_W'(vb);
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cfg_mode   = m;
        cfg_nvec   = NVEC_W'(nv);
        cfg_vbytes = VBYTES_W'(vb);
    endtask

    // Wait until every request is taken and answered, then let the pipe settle
    task automatic drain();
        while (accepted_cnt != pushed_cnt || hv_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Stimulus
    initial begin
        logic [MODE_W-1:0] m;
        int unsigned       nv, vb;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: half level, full set
        queue_req(OP_LOAD, 0, 0, 8'h00);
        queue_req(OP_LOAD, 1023, 2047, 8'hFF);
        queue_req(OP_LOAD, 0, 1, 8'hA5);
        queue_req(OP_GEN, 0, 0, 0);
        queue_req(OP_GEN, 1023, 2047, 8'hFF);
        queue_req(OP_GEN, 1023, 1, 0);
        queue_req(OP_GEN, 1023, 0, 0);
        drain();
        set_cfg(MODE_FULL, 1024, 2048);
        queue_req(OP_GEN, 1023, 2047, 0);
        queue_req(OP_GEN, 1023, 1, 0);
        drain();
        // circular edges of both halves
        set_cfg(MODE_CIRC, 1024, 2048);
        queue_req(OP_GEN, 0, 0, 0);
        queue_req(OP_GEN, 511, 2047, 0);
        queue_req(OP_GEN, 512, 0, 0);
        queue_req(OP_GEN, 1023, 2047, 0);
        drain();
        // odd count, indices past the set, load past the size
        set_cfg(MODE_CIRC, 5, 8);
        queue_req(OP_GEN, 4, 0, 0);
        queue_req(OP_GEN, 2, 1, 0);
        queue_req(OP_GEN, 5, 0, 0);
        queue_req(OP_GEN, 0, 8, 0);
        queue_req(OP_LOAD, 0, 9, 8'h3C);
        drain();
        // unassigned mode: generates flagged, loads still stored
        set_cfg(MODE_NONE, 5, 8);
        queue_req(OP_GEN, 1, 0, 0);
        queue_req(OP_LOAD, 0, 2, 8'h5A);
        drain();
        // zero count and size: everything out of range
        set_cfg(MODE_HALF, 0, 0);
        queue_req(OP_LOAD, 0, 0, 8'h77);
        queue_req(OP_GEN, 0, 0, 0);
        drain();
        // values above the limits clamp to them
        set_cfg(MODE_FULL, 2047, 4095);
        queue_req(OP_GEN, 1023, 2047, 0);
        queue_req(OP_LOAD, 1023, 2047, 8'h81);
        drain();

        // random phases, extremes first
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: set_cfg(MODE_HALF, 1, 1);
                1: set_cfg(MODE_CIRC, 2, 2);
                2: set_cfg(MODE_FULL, 1024, 2048);
                3: set_cfg(MODE_CIRC, 1023, 2048);
                4: set_cfg(MODE_CIRC, 7, 32);
                5: set_cfg(MODE_HALF, 1024, 64);
                6: set_cfg(MODE_FULL, 3, 2047);
                default: begin
                    m  = ($urandom_range(0, 9) == 0) ? MODE_NONE
                                                     : MODE_W'($urandom_range(0, 2));
                    nv = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                                     : $urandom_range(1, 24);
                    vb = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048)
                                                     : $urandom_range(1, 48);
                    set_cfg(m, nv, vb);
                end
            endcase
            // long receiver hold-off so the block backs up into s_tready
            if (ph == 7) hold_req <= hold_req + 1;
            repeat (PHASE_ITEMS) add_random_req();
            drain();
        end

        if (err_cnt == 0 && hv_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Request driver: random gaps, with calm stretches of back-to-back transfers
    int unsigned src_gap   = 0;
    int unsigned src_xfers = 0;
    bit          src_calm  = 1'b0;

    always @(posedge aclk) begin : p_drive
        logic nx_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  = 0;
        end else begin
            nx_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                hv_expect_q.push_back(predict_hv_byte(cur_req));
                accepted_cnt++;
                nx_valid = 1'b0;
                src_xfers++;
                if (src_xfers % 40 == 0) src_calm = ($urandom_range(0, 2) == 0);
                src_gap = draw_wait(src_calm);
            end
            if (!nx_valid) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (req_pending_q.size() > 0) begin
                    cur_req = req_pending_q.pop_front();
                    s_tdata <= S_TDATA_W'({cur_req.byte_val, cur_req.byte_idx,
                                           cur_req.vec_idx});
                    s_tuser <= cur_req.op;
                    nx_valid = 1'b1;
                end
            end
            s_tvalid <= nx_valid;
        end
    end

    // Result monitor: check each transfer against the oldest expectation
    int unsigned sink_wait  = 0;
    int unsigned sink_hold  = 0;
    int unsigned sink_xfers = 0;
    bit          sink_calm  = 1'b0;

    always @(posedge aclk) begin : p_recv
        hv_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (hv_expect_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("unexpected result: byte %02h range flag %0b at %0t",
                                 m_tdata, m_tuser, $realtime);
                end else begin
                    want = hv_expect_q.pop_front();
                    if (m_tdata !== want.out_byte || m_tuser !== want.out_of_range) begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX)
                            $display("mismatch at %0t: byte exp %02h got %02h, flag exp %0b got %0b",
                                     $realtime, want.out_byte, m_tdata,
                                     want.out_of_range, m_tuser);
                    end
                end
                sink_xfers++;
                if (sink_xfers % 40 == 0) sink_calm = ($urandom_range(0, 2) == 0);
                sink_wait = draw_wait(sink_calm);
            end
            if (hold_ack != hold_req) begin
                hold_ack  = hold_req;
                sink_hold = HOLD_CYC;
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run after too long without any transfer or config write
    int unsigned idle_cyc = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cyc = 0;
        end else begin
            idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
